// File: design/bam_pkg.sv
// Shared types, constants and helpers of the block average mosaic
package bam_pkg;

	localparam int BLOCK_SIZE = 16;
	localparam int BLK_LOG    = 4;
	localparam int CH_W       = 8;
	localparam int SUM_W      = CH_W + 2 * BLK_LOG;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 12;
	localparam int COUNT_W    = WIDTH_W + HEIGHT_W;
	localparam int STEP_W     = $clog2(COUNT_W);
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;

	// configuration register indexes
	localparam logic REG_IMAGE_WIDTH  = 1'b0;
	localparam logic REG_IMAGE_HEIGHT = 1'b1;

	// item kinds
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] blue;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] red;
	} pixel_t;

	typedef struct packed {
		logic add;
		logic band_end;
		logic clear;
	} acc_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	// block holding this column starts left of mid row and fits in the row
	function automatic logic in_mosaic(input logic [WIDTH_W-1:0] col,
			input logic [WIDTH_W-1:0] w);
		logic [WIDTH_W:0] start;
		start = {1'b0, col[WIDTH_W-1:BLK_LOG], {BLK_LOG{1'b0}}};
		return (start < {2'b00, w[WIDTH_W-1:1]}) &&
			(start + (WIDTH_W+1)'(BLOCK_SIZE) <= {1'b0, w});
	endfunction

endpackage

// File: design/bam_line_buf.sv
// Band line buffer: one write port and one registered read port
module bam_line_buf import bam_pkg::*; #(
	parameter int DEPTH = 16384,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  pixel_t        wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output pixel_t        rdata
);

	pixel_t mem [DEPTH];

	// read returns the value stored before a write in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/bam_blk_acc.sv
// Per block channel sums of the current band and the averages of the last band
module bam_blk_acc import bam_pkg::*; #(
	parameter int NBLK = 32,
	parameter int BW   = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  acc_ctrl_t     ctrl,
	input  logic [BW-1:0] wr_blk,
	input  pixel_t        pix,
	input  logic [BW-1:0] rd_blk,
	output pixel_t        avg
);

	logic [SUM_W-1:0] red_sum_q   [NBLK];
	logic [SUM_W-1:0] green_sum_q [NBLK];
	logic [SUM_W-1:0] blue_sum_q  [NBLK];
	logic [SUM_W-1:0] red_next    [NBLK];
	logic [SUM_W-1:0] green_next  [NBLK];
	logic [SUM_W-1:0] blue_next   [NBLK];
	pixel_t           avg_q       [NBLK];

	// sums including the item that arrives now
	always_comb begin
		for (int i = 0; i < NBLK; i++) begin
			if (ctrl.add && (wr_blk == BW'(i))) begin
				red_next[i]   = red_sum_q[i] + SUM_W'(pix.red);
				green_next[i] = green_sum_q[i] + SUM_W'(pix.green);
				blue_next[i]  = blue_sum_q[i] + SUM_W'(pix.blue);
			end else begin
				red_next[i]   = red_sum_q[i];
				green_next[i] = green_sum_q[i];
				blue_next[i]  = blue_sum_q[i];
			end
		end
	end

	// accumulate, latch averages at band end, clear at band or image end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NBLK; i++) begin
				red_sum_q[i]   <= '0;
				green_sum_q[i] <= '0;
				blue_sum_q[i]  <= '0;
				avg_q[i]       <= '0;
			end
		end else begin
			for (int i = 0; i < NBLK; i++) begin
				if (ctrl.clear || ctrl.band_end) begin
					red_sum_q[i]   <= '0;
					green_sum_q[i] <= '0;
					blue_sum_q[i]  <= '0;
				end else begin
					red_sum_q[i]   <= red_next[i];
					green_sum_q[i] <= green_next[i];
					blue_sum_q[i]  <= blue_next[i];
				end
				if (ctrl.band_end) begin
					avg_q[i].red   <= red_next[i][SUM_W-1:SUM_W-CH_W];
					avg_q[i].green <= green_next[i][SUM_W-1:SUM_W-CH_W];
					avg_q[i].blue  <= blue_next[i][SUM_W-1:SUM_W-CH_W];
				end
			end
		end
	end

	assign avg = avg_q[rd_blk];

endmodule

// File: design/bam_div.sv
// Bit serial divider that maps the output pixel count to row and column
module bam_div import bam_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [COUNT_W-1:0]  dividend,
	input  logic [WIDTH_W-1:0]  divisor,
	output div_stat_t           stat,
	output logic [HEIGHT_W-1:0] quot,
	output logic [WIDTH_W-1:0]  rem
);

	logic               busy_q;
	logic               fin_q;
	logic [STEP_W-1:0]  step_q;
	logic [COUNT_W-1:0] dvd_q;
	logic [WIDTH_W-1:0] rem_q;
	logic [WIDTH_W:0]   trial;
	logic               fits;

	// one quotient bit per cycle
	assign trial = {rem_q, dvd_q[COUNT_W-1]};
	assign fits  = trial >= {1'b0, divisor};

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			fin_q  <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			fin_q  <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			if (step_q == STEP_W'(COUNT_W - 1)) begin
				busy_q <= 1'b0;
				fin_q  <= 1'b1;
			end
			step_q <= step_q + 1'b1;
		end else begin
			fin_q <= 1'b0;
		end
	end

	// remainder and shifting dividend, quotient fills in from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? WIDTH_W'(trial - {1'b0, divisor}) : trial[WIDTH_W-1:0];
			dvd_q <= {dvd_q[COUNT_W-2:0], fits};
		end
	end

	assign stat.busy = busy_q || fin_q;
	assign stat.done = fin_q;
	assign quot      = dvd_q[HEIGHT_W-1:0];
	assign rem       = rem_q;

endmodule

// File: design/block_average_mosaic.sv
// Block average mosaic over the left half of an RGB raster image
//
// Pixels enter on src in raster order, at most one item per cycle. A pixel
// item (action low) is stored in a band line buffer of sixteen rows; once the
// stream is sixteen rows in, each pixel item also yields the pixel from sixteen
// rows back on the dst channel. After the last row, flush items (action high)
// drain the rest, one pixel each; last_pixel marks the final one, after which
// all counters and block sums are back at zero for the next image.
// Pixels of a complete 16x16 block that starts left of mid row are replaced by
// the block's per channel sum shifted right by 8; a partial bottom band passes.
// Throughput is one item per cycle unless a dst stall or a configuration write
// blocks src. Each taken item with a result loads the line buffer read stage,
// then the output register, which drives dst. When dst stalls, one more item with a result
// is taken into the read stage (items without one still pass), then src_ready
// drops until the output register drains. Reset sets 640 x 480 and empties the
// pipeline. A configuration write blocks src while a bit serial divider
// re-derives the output row and column from the output pixel count.
module block_average_mosaic import bam_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic                wr_index,
	input  logic [HEIGHT_W-1:0] wr_data,
	input  logic                src_valid,
	output logic                src_ready,
	input  logic                action,
	input  logic [CH_W-1:0]     red_in,
	input  logic [CH_W-1:0]     green_in,
	input  logic [CH_W-1:0]     blue_in,
	output logic                dst_valid,
	input  logic                dst_ready,
	output logic [CH_W-1:0]     red_out,
	output logic [CH_W-1:0]     green_out,
	output logic [CH_W-1:0]     blue_out,
	output logic                last_pixel
);

	localparam int DEPTH  = BLOCK_SIZE * MAX_WIDTH;
	localparam int AW     = $clog2(DEPTH);
	localparam int AFULL  = BLK_LOG + WIDTH_W + 1;
	localparam int NBLK   = (MAX_WIDTH / 2 + BLOCK_SIZE - 1) / BLOCK_SIZE;
	localparam int BW     = (NBLK > 1) ? $clog2(NBLK) : 1;
	localparam int W_FULL = (1 << WIDTH_W) - 1;
	localparam int W_CAP  = (MAX_WIDTH > W_FULL) ? W_FULL : MAX_WIDTH;
	localparam int W_RSTI = (W_CAP < RST_WIDTH) ? W_CAP : RST_WIDTH;
	localparam logic [WIDTH_W-1:0]  W_MAX     = WIDTH_W'(W_CAP);
	localparam logic [WIDTH_W-1:0]  W_RST     = WIDTH_W'(W_RSTI);
	localparam logic [HEIGHT_W-1:0] H_RST     = HEIGHT_W'(RST_HEIGHT);
	localparam logic [COUNT_W-1:0]  TOTAL_RST = COUNT_W'(W_RSTI * RST_HEIGHT);

	// configuration and geometry
	logic [WIDTH_W-1:0]  w_q;
	logic [HEIGHT_W-1:0] h_q;
	logic [COUNT_W-1:0]  total_q;
	logic [WIDTH_W-1:0]  wr_w;
	logic [WIDTH_W-1:0]  w_new;
	logic [HEIGHT_W-1:0] h_new;

	// position counters
	logic [WIDTH_W-1:0]  col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic [COUNT_W-1:0]  k_q;
	logic [WIDTH_W-1:0]  ocol_q;
	logic [HEIGHT_W-1:0] orow_q;

	// item decode
	logic        acc_in;
	logic        pix_ok;
	logic        emit;
	logic        last;
	logic        done;
	logic        row_end;
	logic        o_wrap;
	logic        band_full;
	logic        out_mos;
	logic [AFULL-1:0] waddr_full;
	logic [AFULL-1:0] raddr_full;
	logic [WIDTH_W-BLK_LOG-1:0] in_blk_full;
	logic [WIDTH_W-BLK_LOG-1:0] out_blk_full;
	pixel_t      in_pix;
	pixel_t      rd_pix;
	pixel_t      avg_rd;
	acc_ctrl_t   acc_ctrl;

	// divider
	div_stat_t           div_stat;
	logic [HEIGHT_W-1:0] div_row;
	logic [WIDTH_W-1:0]  div_col;

	// pipeline
	logic   v_s1;
	logic   mos_s1;
	logic   last_s1;
	pixel_t avg_s1;
	logic   s1_adv;
	logic   out_v_q;
	logic   out_last_q;
	pixel_t out_pix_q;

	// effective size of a written register
	assign wr_w  = wr_data[WIDTH_W-1:0];
	assign w_new = (wr_w == '0) ? WIDTH_W'(1) : ((wr_w > W_MAX) ? W_MAX : wr_w);
	assign h_new = (wr_data == '0) ? HEIGHT_W'(1) : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= W_RST;
			h_q     <= H_RST;
			total_q <= TOTAL_RST;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_IMAGE_WIDTH:  w_q <= w_new;
					REG_IMAGE_HEIGHT: h_q <= h_new;
					default: ;
				endcase
			end
			total_q <= COUNT_W'(w_q) * COUNT_W'(h_q);
		end
	end

	// handshake
	assign s1_adv    = !out_v_q || dst_ready;
	assign src_ready = !div_stat.busy && !wr_en && (!v_s1 || s1_adv);
	assign acc_in    = src_valid && src_ready;

	// what this item does
	assign pix_ok  = (action == ACT_PIXEL) && (row_q < h_q);
	assign emit    = (k_q < total_q) && ((action == ACT_FLUSH) ? (row_q >= h_q)
		: (pix_ok && (row_q >= HEIGHT_W'(BLOCK_SIZE))));
	assign last    = (k_q + COUNT_W'(1)) == total_q;
	assign done    = emit && last;
	assign row_end = ({1'b0, col_q} + (WIDTH_W+1)'(1)) >= {1'b0, w_q};
	assign o_wrap  = ({1'b0, ocol_q} + (WIDTH_W+1)'(1)) >= {1'b0, w_q};

	// output pixel lies in a complete band and a mosaic block
	assign band_full = ({1'b0, orow_q[HEIGHT_W-1:BLK_LOG], {BLK_LOG{1'b0}}}
		+ (HEIGHT_W+1)'(BLOCK_SIZE)) <= {1'b0, h_q};
	assign out_mos   = band_full && in_mosaic(ocol_q, w_q);

	// line buffer addresses
	assign waddr_full = AFULL'(row_q[BLK_LOG-1:0]) * AFULL'(w_q) + AFULL'(col_q);
	assign raddr_full = AFULL'(orow_q[BLK_LOG-1:0]) * AFULL'(w_q) + AFULL'(ocol_q);
	assign in_blk_full  = col_q[WIDTH_W-1:BLK_LOG];
	assign out_blk_full = ocol_q[WIDTH_W-1:BLK_LOG];

	assign in_pix.red   = red_in;
	assign in_pix.green = green_in;
	assign in_pix.blue  = blue_in;

	// block sum control
	assign acc_ctrl.add      = acc_in && pix_ok && in_mosaic(col_q, w_q);
	assign acc_ctrl.band_end = acc_in && pix_ok && row_end &&
		(row_q[BLK_LOG-1:0] == BLK_LOG'(BLOCK_SIZE - 1));
	assign acc_ctrl.clear    = acc_in && done;

	// input and output position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			k_q    <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (acc_in) begin
			if (done) begin
				col_q  <= '0;
				row_q  <= '0;
				k_q    <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (emit) begin
					k_q <= k_q + 1'b1;
					if (o_wrap) begin
						ocol_q <= '0;
						orow_q <= orow_q + 1'b1;
					end else begin
						ocol_q <= ocol_q + 1'b1;
					end
				end
				if (pix_ok) begin
					if (row_end) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
			end
		end else if (div_stat.done) begin
			ocol_q <= div_col;
			orow_q <= div_row;
		end
	end

	bam_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (wr_en),
		.dividend (k_q),
		.divisor  (w_q),
		.stat     (div_stat),
		.quot     (div_row),
		.rem      (div_col)
	);

	bam_line_buf #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_line_buf (
		.clk   (clk),
		.we    (acc_in && pix_ok),
		.waddr (waddr_full[AW-1:0]),
		.wdata (in_pix),
		.re    (acc_in && emit),
		.raddr (raddr_full[AW-1:0]),
		.rdata (rd_pix)
	);

	bam_blk_acc #(
		.NBLK (NBLK),
		.BW   (BW)
	) u_blk_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (acc_ctrl),
		.wr_blk (in_blk_full[BW-1:0]),
		.pix    (in_pix),
		.rd_blk (out_blk_full[BW-1:0]),
		.avg    (avg_rd)
	);

	// read stage, waits on the line buffer data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc_in) begin
			v_s1 <= emit;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in && emit) begin
			mos_s1  <= out_mos;
			last_s1 <= last;
			avg_s1  <= avg_rd;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (s1_adv) begin
			out_v_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && v_s1) begin
			out_pix_q  <= mos_s1 ? avg_s1 : rd_pix;
			out_last_q <= last_s1;
		end
	end

	assign dst_valid  = out_v_q;
	assign red_out    = out_pix_q.red;
	assign green_out  = out_pix_q.green;
	assign blue_out   = out_pix_q.blue;
	assign last_pixel = out_last_q;

endmodule
